### rtl/srsa_pkg.sv
// shared types and codes for the scoped register stack allocator
`default_nettype none
package srsa_pkg;

  localparam logic [3:0] OP_ALLOC_LOCAL = 4'd0;
  localparam logic [3:0] OP_ALLOC_TEMP  = 4'd1;
  localparam logic [3:0] OP_FREE_TEMP   = 4'd2;
  localparam logic [3:0] OP_ALLOC_FRAME = 4'd3;
  localparam logic [3:0] OP_FREE_FRAME  = 4'd4;
  localparam logic [3:0] OP_ENTER       = 4'd5;
  localparam logic [3:0] OP_EXIT        = 4'd6;
  localparam logic [3:0] OP_MARK        = 4'd7;
  localparam logic [3:0] OP_UNMARK      = 4'd8;
  localparam logic [3:0] OP_QUERY_LIVE  = 4'd9;
  localparam logic [3:0] OP_QUERY_AVAIL = 4'd10;
  localparam logic [3:0] OP_RESET_TOP   = 4'd11;
  localparam logic [3:0] OP_CLEAR       = 4'd12;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_LOCALS_FULL = 3'd1;
  localparam logic [2:0] ST_STACK_FULL  = 3'd2;
  localparam logic [2:0] ST_FRAME_FIT   = 3'd3;
  localparam logic [2:0] ST_SCOPE_FULL  = 3'd4;

  typedef struct packed {
    logic [3:0] operation;
    logic [8:0] position;
    logic [8:0] count;
  } req_t;

  typedef struct packed {
    logic [7:0] register_res;
    logic       answer;
    logic [2:0] status;
    logic [8:0] top_now;
    logic [8:0] locals_now;
  } rsp_t;

endpackage
`default_nettype wire

### rtl/scoped_register_stack_allocator.sv
// scoped register stack allocator: sequencer, live map and scope stack
// steps: most operations execute and then hold their result; exit adds a step that restores
// the saved counts; alloc temp probes the live map one register at a time, waiting on each
// read; reset top and clear sweep one register a cycle over the range they clear
// throughput: one item at a time; a new item is taken only after the result is taken
// reset: synchronous rst clears counts and scope level, then a pass clears the live map
`default_nettype none
module scoped_register_stack_allocator #(
  parameter int NUM_REGS    = 256,
  parameter int SCOPE_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire srsa_pkg::req_t in_data,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      srsa_pkg::rsp_t out_data
);
  import srsa_pkg::*;

  localparam int CW = $clog2(NUM_REGS + 1);
  localparam int IW = $clog2(NUM_REGS);
  localparam int WW = ((CW > 9) ? CW : 9) + 1;
  localparam int SW = $clog2(SCOPE_DEPTH + 1);
  localparam int SI = $clog2(SCOPE_DEPTH);
  localparam logic [CW-1:0] NREG = CW'(NUM_REGS);

  localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_SCAN1 = 3'd2,
                         S_SCAN2 = 3'd3, S_SWEEP = 3'd4, S_EXIT = 3'd5, S_OUT = 3'd6,
                         S_INIT = 3'd7;

  logic [2:0] state;
  req_t req;
  logic [CW-1:0] local_total, top_of_stack, ptr, lim;
  logic [SW-1:0] scope_level;
  logic live_mem [NUM_REGS];
  logic live_rd, rd_wait;
  logic [IW-1:0] rd_addr, wr_addr;
  logic wr_en, wr_bit;
  logic [2*CW-1:0] scope_saves [SCOPE_DEPTH];
  logic [2*CW-1:0] save_rd;
  rsp_t rsp;

  // position widened past the count width for compares
  logic [WW-1:0] pos_w, sum_w;
  logic pos_ok;
  assign pos_w = WW'(req.position);
  assign pos_ok = pos_w < WW'(NUM_REGS);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = {rsp.register_res, rsp.answer, rsp.status,
                      9'(top_of_stack), 9'(local_total)};

  // while idle the read follows the offered item so queries find their bit ready
  assign rd_addr = (state == S_IDLE) ? IW'(in_data.position) : ptr[IW-1:0];

  always_comb begin
    sum_w = WW'(top_of_stack) + WW'(req.count);
    if (req.operation == OP_FREE_FRAME) sum_w = pos_w + WW'(req.count);
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = ptr[IW-1:0];
    wr_bit = 1'b0;
    if (state == S_EXEC && pos_ok
        && (req.operation == OP_MARK || req.operation == OP_UNMARK)) begin
      wr_en = 1'b1;
      wr_addr = pos_w[IW-1:0];
      wr_bit = (req.operation == OP_MARK);
    end else if ((state == S_SWEEP && ptr < lim) || (state == S_INIT && ptr < NREG)) begin
      wr_en = 1'b1;
    end
  end

  // live map: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) live_mem[wr_addr] <= wr_bit;
    live_rd <= live_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && req.operation == OP_ENTER && scope_level < SW'(SCOPE_DEPTH))
      scope_saves[scope_level[SI-1:0]] <= {local_total, top_of_stack};
    if (state == S_EXEC) save_rd <= scope_saves[SI'(scope_level - SW'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      local_total <= '0;
      top_of_stack <= '0;
      scope_level <= '0;
      ptr <= '0;
      rd_wait <= 1'b0;
    end else begin
      unique case (state)
        S_INIT:
          if (ptr >= NREG) state <= S_IDLE;
          else ptr <= ptr + CW'(1);
        S_IDLE: if (in_valid) begin
          req <= in_data;
          rsp <= '0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_OUT;
          case (req.operation)
            OP_ALLOC_LOCAL:
              if (local_total >= NREG) rsp.status <= ST_LOCALS_FULL;
              else begin
                rsp.register_res <= 8'(local_total);
                local_total <= local_total + CW'(1);
                if (local_total + CW'(1) > top_of_stack) top_of_stack <= local_total + CW'(1);
              end
            OP_ALLOC_TEMP:
              if (top_of_stack >= NREG) rsp.status <= ST_STACK_FULL;
              else begin
                ptr <= top_of_stack;
                rd_wait <= 1'b1;
                state <= S_SCAN1;
              end
            OP_FREE_TEMP:
              if (top_of_stack > local_total) top_of_stack <= top_of_stack - CW'(1);
            OP_ALLOC_FRAME:
              if (sum_w > WW'(NUM_REGS)) rsp.status <= ST_FRAME_FIT;
              else begin
                rsp.register_res <= 8'(top_of_stack);
                top_of_stack <= CW'(sum_w);
              end
            OP_FREE_FRAME:
              if (req.count != 9'd0 && sum_w == WW'(top_of_stack))
                top_of_stack <= CW'(req.position);
            OP_ENTER:
              if (scope_level >= SW'(SCOPE_DEPTH)) rsp.status <= ST_SCOPE_FULL;
              else scope_level <= scope_level + SW'(1);
            OP_EXIT:
              if (scope_level != '0) begin
                scope_level <= scope_level - SW'(1);
                state <= S_EXIT;
              end
            OP_QUERY_LIVE: rsp.answer <= pos_ok && live_rd;
            OP_QUERY_AVAIL:
              rsp.answer <= pos_ok && pos_w >= WW'(top_of_stack) && !live_rd;
            OP_RESET_TOP: begin
              // a target at or above the top sweeps nothing
              ptr <= (pos_w < WW'(local_total)) ? local_total
                   : (pos_w < WW'(top_of_stack)) ? CW'(req.position) : top_of_stack;
              lim <= top_of_stack;
              state <= S_SWEEP;
            end
            OP_CLEAR: begin
              local_total <= '0;
              top_of_stack <= '0;
              scope_level <= '0;
              ptr <= '0;
              lim <= NREG;
              state <= S_SWEEP;
            end
            // mark and unmark go through the live map write port
            default: ;
          endcase
        end
        S_SCAN1:
          if (rd_wait) rd_wait <= 1'b0;
          else if (ptr >= NREG) begin
            ptr <= local_total;
            rd_wait <= 1'b1;
            state <= S_SCAN2;
          end else if (!live_rd) begin
            rsp.register_res <= 8'(ptr);
            top_of_stack <= ptr + CW'(1);
            state <= S_OUT;
          end else begin
            ptr <= ptr + CW'(1);
            rd_wait <= 1'b1;
          end
        S_SCAN2:
          if (rd_wait) rd_wait <= 1'b0;
          else if (ptr >= top_of_stack) begin
            rsp.register_res <= 8'(top_of_stack);
            top_of_stack <= top_of_stack + CW'(1);
            state <= S_OUT;
          end else if (!live_rd) begin
            rsp.register_res <= 8'(ptr);
            state <= S_OUT;
          end else begin
            ptr <= ptr + CW'(1);
            rd_wait <= 1'b1;
          end
        S_SWEEP:
          if (ptr >= lim) begin
            if (req.operation == OP_RESET_TOP) begin
              // lim holds the old top; lower only when target sat below it
              if (WW'(local_total) > pos_w) begin
                if (local_total < lim) top_of_stack <= local_total;
              end else if (pos_w < WW'(lim)) top_of_stack <= CW'(req.position);
            end
            state <= S_OUT;
          end else begin
            ptr <= ptr + CW'(1);
          end
        S_EXIT: begin
          local_total <= save_rd[2*CW-1:CW];
          top_of_stack <= (save_rd[CW-1:0] < save_rd[2*CW-1:CW])
                          ? save_rd[2*CW-1:CW] : save_rd[CW-1:0];
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top_of_stack <= NREG) else $error("top beyond register file");
  a_scope_range: assert property (@(posedge clk) disable iff (rst)
    scope_level <= SW'(SCOPE_DEPTH)) else $error("scope level overflow");
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("accepting while result pending");

endmodule
`default_nettype wire

### bench/tb_scoped_register_stack_allocator.sv
// testbench for the scoped register stack allocator: directed and random items checked against a predictor
`default_nettype none
module tb_scoped_register_stack_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import srsa_pkg::*;

  localparam int NREGS = 256;
  localparam int SDEPTH = 16;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  scoped_register_stack_allocator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  int unsigned loc_cnt, stk_top, scope_lvl;
  int unsigned save_loc[SDEPTH];
  int unsigned save_top[SDEPTH];
  bit live[NREGS];

  rsp_t expected_q[$];
  int mismatches = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit hold_off = 1'b0;
  int unsigned idle_cycles = 0;
  bit timed_out = 1'b0;

  function automatic bit live_at(int unsigned r);
    return r < NREGS && live[r];
  endfunction

  function automatic void clear_state();
    loc_cnt = 0;
    stk_top = 0;
    scope_lvl = 0;
    foreach (live[i]) live[i] = 1'b0;
  endfunction

  function automatic rsp_t allocate_predict(req_t rq);
    rsp_t rs;
    int unsigned p, c, r;
    bit found;
    rs = '0;
    p = rq.position;
    c = rq.count;
    case (rq.operation)
      OP_ALLOC_LOCAL: begin
        if (loc_cnt >= NREGS) rs.status = ST_LOCALS_FULL;
        else begin
          rs.register_res = loc_cnt[7:0];
          loc_cnt++;
          if (loc_cnt > stk_top) stk_top = loc_cnt;
        end
      end
      OP_ALLOC_TEMP: begin
        if (stk_top >= NREGS) rs.status = ST_STACK_FULL;
        else begin
          found = 1'b0;
          r = stk_top;
          for (int unsigned i = stk_top; i < NREGS && !found; i++)
            if (!live_at(i)) begin r = i; found = 1'b1; end
          for (int unsigned i = loc_cnt; i < stk_top && !found; i++)
            if (!live_at(i)) begin r = i; found = 1'b1; end
          rs.register_res = r[7:0];
          if (r >= stk_top) stk_top = r + 1;
        end
      end
      OP_FREE_TEMP: if (stk_top > loc_cnt) stk_top--;
      OP_ALLOC_FRAME: begin
        if (stk_top + c > NREGS) rs.status = ST_FRAME_FIT;
        else begin
          rs.register_res = stk_top[7:0];
          stk_top += c;
        end
      end
      OP_FREE_FRAME: if (c != 0 && p + c == stk_top) stk_top = p;
      OP_ENTER: begin
        if (scope_lvl >= SDEPTH) rs.status = ST_SCOPE_FULL;
        else begin
          save_loc[scope_lvl] = loc_cnt;
          save_top[scope_lvl] = stk_top;
          scope_lvl++;
        end
      end
      OP_EXIT: begin
        if (scope_lvl != 0) begin
          scope_lvl--;
          loc_cnt = save_loc[scope_lvl];
          stk_top = save_top[scope_lvl];
          if (stk_top < loc_cnt) stk_top = loc_cnt;
        end
      end
      OP_MARK: if (p < NREGS) live[p] = 1'b1;
      OP_UNMARK: if (p < NREGS) live[p] = 1'b0;
      OP_QUERY_LIVE: rs.answer = live_at(p);
      OP_QUERY_AVAIL: rs.answer = p < NREGS && p >= stk_top && !live_at(p);
      OP_RESET_TOP: begin
        if (p < loc_cnt) p = loc_cnt;
        if (p < stk_top) begin
          for (int unsigned i = p; i < stk_top; i++)
            if (i < NREGS) live[i] = 1'b0;
          stk_top = p;
        end
      end
      OP_CLEAR: clear_state();
      default: ;
    endcase
    rs.top_now = stk_top[8:0];
    rs.locals_now = loc_cnt[8:0];
    return rs;
  endfunction

  // valid stays up between back to back items and drops only while the sender idles
  task automatic send_item(input logic [3:0] op, input int unsigned pos, input int unsigned cnt);
    req_t rq;
    rq.operation = op;
    rq.position = pos[8:0];
    rq.count = cnt[8:0];
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= rq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.insert(expected_q.size(), allocate_predict(rq));
    @(negedge clk);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= !(recv_idle != 0 && $urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        rsp_t ex;
        ex = expected_q.pop_front();
        if (out_data !== ex) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", ex, out_data);
        end
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (NREGS + 8) @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(OP_QUERY_LIVE, 0, 0);
    send_item(OP_QUERY_AVAIL, 256, 0);
    send_item(OP_EXIT, 0, 0);
    send_item(OP_ALLOC_LOCAL, 0, 0);
    send_item(OP_MARK, 1, 0);
    send_item(OP_MARK, 255, 0);
    send_item(OP_MARK, 256, 0);
    send_item(OP_QUERY_LIVE, 255, 0);
    send_item(OP_ALLOC_TEMP, 0, 0);
    send_item(OP_ALLOC_FRAME, 0, 256);
    send_item(OP_ALLOC_FRAME, 0, 5);
    send_item(OP_FREE_FRAME, 2, 5);
    send_item(OP_FREE_FRAME, 3, 0);
    send_item(OP_ALLOC_FRAME, 0, 511);
    send_item(OP_FREE_TEMP, 0, 0);
    send_item(OP_UNMARK, 255, 0);
    send_item(OP_RESET_TOP, 0, 0);
    send_item(OP_RESET_TOP, 511, 0);
    send_item(4'd13, 511, 511);
    send_item(4'd15, 0, 0);
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_ALLOC_FRAME, 0, 256);
    send_item(OP_ALLOC_TEMP, 0, 0);
    send_item(OP_ALLOC_FRAME, 0, 1);
    send_item(OP_CLEAR, 0, 0);
  endtask

  task automatic test_limits();
    // fill locals and the scope stack past their limits, then search for temps with every third register live
    for (int i = 0; i < 18; i++) send_item(OP_ENTER, 0, 0);
    for (int i = 0; i < 257; i++) send_item(OP_ALLOC_LOCAL, 0, 0);
    send_item(OP_ALLOC_TEMP, 0, 0);
    for (int i = 0; i < 18; i++) send_item(OP_EXIT, 0, 0);
    for (int i = 0; i < 256; i += 3) send_item(OP_MARK, i, 0);
    for (int i = 0; i < 6; i++) send_item(OP_ALLOC_TEMP, 0, 0);
    send_item(OP_RESET_TOP, 0, 0);
    send_item(OP_CLEAR, 0, 0);
  endtask

  task automatic random_items(input int n);
    int unsigned k, pos, cnt;
    logic [3:0] op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      pos = (k < 8) ? $urandom_range(511) : $urandom_range(stk_top + 8 > 256 ? 256 : stk_top + 8);
      cnt = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(12);
      if (k < 12) op = OP_ALLOC_LOCAL;
      else if (k < 26) op = OP_ALLOC_TEMP;
      else if (k < 32) op = OP_FREE_TEMP;
      else if (k < 40) op = OP_ALLOC_FRAME;
      else if (k < 48) begin
        op = OP_FREE_FRAME;
        // mostly a frame that sits at the top
        if (k < 45 && cnt != 0 && cnt <= stk_top) pos = stk_top - cnt;
      end else if (k < 56) op = OP_ENTER;
      else if (k < 64) op = OP_EXIT;
      else if (k < 72) op = OP_MARK;
      else if (k < 77) op = OP_UNMARK;
      else if (k < 83) op = OP_QUERY_LIVE;
      else if (k < 89) op = OP_QUERY_AVAIL;
      else if (k < 95) op = OP_RESET_TOP;
      else if (k < 97) op = OP_CLEAR;
      else op = 4'($urandom_range(15));
      send_item(op, pos, cnt);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      random_items(30);
    join
  endtask

  initial begin
    clear_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle = 17; recv_idle = 79;
    test_directed();
    test_limits();
    random_items(350);
    send_idle = 79; recv_idle = 17;
    random_items(350);
    test_backpressure();
    send_idle = 0; recv_idle = 0;
    random_items(200);
    drain();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/srsa_pkg.sv
rtl/scoped_register_stack_allocator.sv
bench/tb_scoped_register_stack_allocator.sv
